// ===== src/bfcg_pkg.sv =====
package bfcg_pkg;
  localparam int MAX_DIM_DEF = 4096;
  localparam int COORD_W = 12;
  localparam int CHAN_W = 8;
  localparam int CHANNELS = 4;
  localparam int CFG_W = 32;
  localparam int SIZE_W = 13;
  localparam int IDX_W = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_TOP_LEFT     = 3'd0,
    REG_TOP_RIGHT    = 3'd1,
    REG_BOTTOM_LEFT  = 3'd2,
    REG_BOTTOM_RIGHT = 3'd3,
    REG_WIDTH        = 3'd4,
    REG_HEIGHT       = 3'd5
  } reg_idx_t;
endpackage

// ===== src/bfcg_if.sv =====
interface bfcg_pixel_if;
  logic valid;
  logic ready;
  logic [bfcg_pkg::COORD_W-1:0] row;
  logic [bfcg_pkg::COORD_W-1:0] column;
  modport source (output valid, row, column, input ready);
  modport sink (input valid, row, column, output ready);
endinterface

interface bfcg_color_if;
  logic valid;
  logic ready;
  logic [bfcg_pkg::CHAN_W-1:0] red;
  logic [bfcg_pkg::CHAN_W-1:0] green;
  logic [bfcg_pkg::CHAN_W-1:0] blue;
  logic [bfcg_pkg::CHAN_W-1:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== src/bfcg_weight.sv =====
module bfcg_weight #(
  parameter int DW = 13,
  parameter int PW = 2 * DW,
  parameter int SW = PW + bfcg_pkg::CHAN_W
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic in_valid,
  input  logic [DW-1:0] h_in,
  input  logic [DW-1:0] w_in,
  input  logic [DW-1:0] size_h,
  input  logic [DW-1:0] size_w,
  input  logic [3:0][bfcg_pkg::CFG_W-1:0] corners,
  output logic out_valid,
  output logic [PW-1:0] den,
  output logic [bfcg_pkg::CHANNELS-1:0][SW-1:0] sums
);
  logic v1, v2;
  logic [DW-1:0] a, b, hh, ww, sh, sw;
  logic [PW-1:0] wtl, wtr, wbl, wbr, den2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // clamp past the last row or column
      hh <= (h_in >= size_h) ? size_h - DW'(1) : h_in;
      ww <= (w_in >= size_w) ? size_w - DW'(1) : w_in;
      a  <= size_h - ((h_in >= size_h) ? size_h - DW'(1) : h_in);
      b  <= size_w - ((w_in >= size_w) ? size_w - DW'(1) : w_in);
      sh <= size_h;
      sw <= size_w;
      wtl  <= PW'(a) * PW'(b);
      wtr  <= PW'(a) * PW'(ww);
      wbl  <= PW'(hh) * PW'(b);
      wbr  <= PW'(hh) * PW'(ww);
      den2 <= PW'(sh) * PW'(sw);
      den  <= den2;
      for (int k = 0; k < bfcg_pkg::CHANNELS; k++) begin
        sums[k] <= SW'(corners[0][8*(3-k) +: 8]) * SW'(wtl)
                 + SW'(corners[1][8*(3-k) +: 8]) * SW'(wtr)
                 + SW'(corners[2][8*(3-k) +: 8]) * SW'(wbl)
                 + SW'(corners[3][8*(3-k) +: 8]) * SW'(wbr);
      end
    end
  end
endmodule

// ===== src/bfcg_cell.sv =====
module bfcg_cell #(
  parameter int PW = 26,
  parameter int SW = 34,
  parameter int BIT = 7
) (
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic in_valid,
  input  logic [PW-1:0] in_den,
  input  logic [bfcg_pkg::CHANNELS-1:0][SW-1:0] in_rem,
  input  logic [bfcg_pkg::CHANNELS-1:0][bfcg_pkg::CHAN_W-1:0] in_quo,
  output logic out_valid,
  output logic [PW-1:0] out_den,
  output logic [bfcg_pkg::CHANNELS-1:0][SW-1:0] out_rem,
  output logic [bfcg_pkg::CHANNELS-1:0][bfcg_pkg::CHAN_W-1:0] out_quo
);
  logic [SW:0] dsh;
  logic [bfcg_pkg::CHANNELS-1:0][SW-1:0] rem_next;
  logic [bfcg_pkg::CHANNELS-1:0][bfcg_pkg::CHAN_W-1:0] quo_next;

  assign dsh = (SW+1)'(in_den) << BIT;

  always_comb begin
    for (int k = 0; k < bfcg_pkg::CHANNELS; k++) begin
      quo_next[k] = in_quo[k];
      if ({1'b0, in_rem[k]} >= dsh) begin
        rem_next[k] = SW'({1'b0, in_rem[k]} - dsh);
        quo_next[k][BIT] = 1'b1;
      end else begin
        rem_next[k] = in_rem[k];
        quo_next[k][BIT] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_den <= in_den;
      out_rem <= rem_next;
      out_quo <= quo_next;
    end
  end
endmodule

// ===== src/bilinear_four_corner_gradient_top.sv =====
// Channel   Dir  Payload                  Handshake
// pixel     in   row, column              valid / ready
// color     out  red, green, blue, alpha  valid / ready
// cfg       in   cfg_index, cfg_data      cfg_we, no wait
// One pixel per cycle while the output is not stalled: clamp, weight multiply, corner
// multiply-add, then eight restoring divide cells, one quotient bit each.
// Reset (rst, synchronous) empties the pipeline, corners go to 0, sizes to 1.
// A stalled output holds the whole chain; pixel.ready drops in the same cycle.
module bilinear_four_corner_gradient_top #(
  parameter int MAX_DIM = bfcg_pkg::MAX_DIM_DEF
) (
  input  logic clk,
  input  logic rst,
  bfcg_pixel_if.sink pixel,
  bfcg_color_if.source color,
  input  logic cfg_we,
  input  logic [bfcg_pkg::IDX_W-1:0] cfg_index,
  input  logic [bfcg_pkg::CFG_W-1:0] cfg_data
);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int PW = 2 * DW;
  localparam int SW = PW + bfcg_pkg::CHAN_W;
  localparam int NC = bfcg_pkg::CHAN_W;

  logic [3:0][bfcg_pkg::CFG_W-1:0] corners;
  logic [bfcg_pkg::SIZE_W-1:0] width, height;
  logic [DW-1:0] size_w, size_h;
  logic advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      corners <= '0;
      width <= bfcg_pkg::SIZE_W'(1);
      height <= bfcg_pkg::SIZE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        bfcg_pkg::REG_TOP_LEFT:     corners[0] <= cfg_data;
        bfcg_pkg::REG_TOP_RIGHT:    corners[1] <= cfg_data;
        bfcg_pkg::REG_BOTTOM_LEFT:  corners[2] <= cfg_data;
        bfcg_pkg::REG_BOTTOM_RIGHT: corners[3] <= cfg_data;
        bfcg_pkg::REG_WIDTH:  width <= cfg_data[bfcg_pkg::SIZE_W-1:0];
        bfcg_pkg::REG_HEIGHT: height <= cfg_data[bfcg_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DW-1:0] eff(input logic [bfcg_pkg::SIZE_W-1:0] v);
    logic [31:0] s;
    s = 32'(v);
    if (s == 32'd0) s = 32'd1;
    if (s > 32'(MAX_DIM)) s = 32'(MAX_DIM);
    return s[DW-1:0];
  endfunction

  assign size_w = eff(width);
  assign size_h = eff(height);

  assign advance = !color.valid || color.ready;
  assign pixel.ready = advance;

  logic [NC:0] v;
  logic [NC:0][PW-1:0] d;
  logic [NC:0][bfcg_pkg::CHANNELS-1:0][SW-1:0] r;
  logic [NC:0][bfcg_pkg::CHANNELS-1:0][NC-1:0] q;

  bfcg_weight #(.DW(DW), .PW(PW), .SW(SW)) u_weight (
    .clk(clk), .rst(rst), .advance(advance),
    .in_valid(pixel.valid),
    .h_in(DW'(pixel.row)), .w_in(DW'(pixel.column)),
    .size_h(size_h), .size_w(size_w), .corners(corners),
    .out_valid(v[0]), .den(d[0]), .sums(r[0])
  );
  assign q[0] = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    bfcg_cell #(.PW(PW), .SW(SW), .BIT(NC - 1 - i)) u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .in_valid(v[i]), .in_den(d[i]), .in_rem(r[i]), .in_quo(q[i]),
      .out_valid(v[i+1]), .out_den(d[i+1]), .out_rem(r[i+1]), .out_quo(q[i+1])
    );
  end

  assign color.valid = v[NC];
  assign color.red   = q[NC][0];
  assign color.green = q[NC][1];
  assign color.blue  = q[NC][2];
  assign color.alpha = q[NC][3];

`ifndef NO_ASSERTIONS
  a_rst_empty: assert property (@(posedge clk) rst |=> !color.valid)
    else $error("output valid after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (color.valid && !color.ready) |=> (color.valid && $stable(color.red)
      && $stable(color.alpha)))
    else $error("stalled result changed");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (color.valid && !color.ready) |-> !pixel.ready)
    else $error("request taken while output stalled");
`endif
endmodule
